// ===== hw/rtl/qss_pkg.sv =====
// ----------------------------------------------------------------------------
// qss_pkg
// Types shared by the block sorter: channel payloads and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package qss_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      run_end;
    logic                      overflowed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POP_W,
    ST_PIV_W,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SW_B,
    ST_SW_J,
    ST_FS_B,
    ST_FS_H,
    ST_PUSH_L,
    ST_PUSH_R,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qss_ram.sv =====
// ----------------------------------------------------------------------------
// qss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module qss_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/quicksort_sorter.sv =====
// ----------------------------------------------------------------------------
// quicksort_sorter
// Block sorter: collects signed 32-bit values, sorts them ascending by
// Lomuto quicksort with an explicit range stack, then streams them out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one value per transaction,
//   block_end set on the last value of a block. in_stall is low while
//   loading. Values past MAX_ITEMS are dropped and flag the block.
//   After the block_end transaction in_stall stays high while the block is
//   sorted and emitted; it drops again once the last result is taken.
//   Sort time: one shared compare unit and a value RAM with one registered
//   read port set the pace. Per range the sequencer pops it and fetches the
//   pivot, reads and compares each scanned element, swaps each element less
//   than the pivot to the bound, then closes the scan, places the pivot and
//   pushes the subranges. An init step starts the sort and a pop of the empty
//   stack ends it. Already ascending input is the worst case.
//   Output channel (out_valid / out_stall / out_data): one sorted value per
//   transaction, run_end on the last, overflowed on all results of a block
//   that lost values. The next result is fetched only after one is taken;
//   out_data is registered and holds while out_stall is high.
//   Reset (rst_n low, synchronous) empties the block and the range stack.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_sorter
  import qss_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  seq_state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;   // values stored in this block
  logic [CW-1:0] sp_r, sp_nxt;         // pending ranges
  logic [CW-1:0] k_r, k_nxt;           // emit index
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] hi_r, hi_nxt;
  logic [IW-1:0] bound_r, bound_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [VALUE_W-1:0] pivot_r, pivot_nxt;
  logic [VALUE_W-1:0] vj_r, vj_nxt;
  logic [VALUE_W-1:0] tmp_r, tmp_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  // value store ports
  logic               st_we;
  logic [IW-1:0]      st_waddr, st_raddr;
  logic [VALUE_W-1:0] st_wdata, st_rdata;
  // range stack ports
  logic               rs_we;
  logic [2*IW-1:0]    rs_wdata, rs_rdata;
  logic [IW-1:0]      rs_waddr, rs_raddr;

  logic          in_acc, out_acc;
  logic          has_room, last_out, is_less, scan_more;
  logic [CW-1:0] sp_dec, k_inc;
  logic [IW:0]   right_lo;
  logic [IW-1:0] left_hi;
  logic [IW-1:0] rd_lo, rd_hi;

  qss_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qss_ram #(.DEPTH(MAX_ITEMS), .WIDTH(2*IW)) u_stack (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;

  assign has_room  = (count_r < CW'(MAX_ITEMS));
  assign k_inc     = k_r + CW'(1);
  assign last_out  = (k_inc == count_r);
  assign sp_dec    = sp_r - CW'(1);
  assign is_less   = ($signed(st_rdata) < $signed(pivot_r));
  assign scan_more = (j_r < hi_r);
  assign right_lo  = {1'b0, bound_r} + (IW+1)'(1);
  assign left_hi   = bound_r - IW'(1);
  assign rd_lo     = rs_rdata[2*IW-1:IW];
  assign rd_hi     = rs_rdata[IW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (in_acc && in_data.block_end) state_nxt = ST_INIT;
      ST_INIT:      state_nxt = (count_r < CW'(2)) ? ST_EMIT_RD : ST_POP;
      ST_POP:       state_nxt = (sp_r == '0) ? ST_EMIT_RD : ST_POP_W;
      ST_POP_W:     state_nxt = ST_PIV_W;
      ST_PIV_W:     state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:   state_nxt = scan_more ? ST_SCAN_CMP : ST_FS_B;
      ST_SCAN_CMP:  state_nxt = is_less ? ST_SW_B : ST_SCAN_RD;
      ST_SW_B:      state_nxt = ST_SW_J;
      ST_SW_J:      state_nxt = ST_SCAN_RD;
      ST_FS_B:      state_nxt = ST_FS_H;
      ST_FS_H:      state_nxt = ST_PUSH_L;
      ST_PUSH_L:    state_nxt = ST_PUSH_R;
      ST_PUSH_R:    state_nxt = ST_POP;
      ST_EMIT_RD:   state_nxt = ST_EMIT_LD;
      ST_EMIT_LD:   state_nxt = ST_EMIT_HOLD;
      ST_EMIT_HOLD: if (out_acc) state_nxt = last_out ? ST_LOAD : ST_EMIT_RD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt     = count_r;
    sp_nxt        = sp_r;
    k_nxt         = k_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bound_nxt     = bound_r;
    j_nxt         = j_r;
    pivot_nxt     = pivot_r;
    vj_nxt        = vj_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    st_we         = 1'b0;
    st_waddr      = count_r[IW-1:0];
    st_wdata      = in_data.sample_value;
    st_raddr      = j_r;
    rs_we         = 1'b0;
    rs_waddr      = sp_r[IW-1:0];
    rs_wdata      = {lo_r, left_hi};
    rs_raddr      = sp_dec[IW-1:0];
    unique case (state_r)
      ST_LOAD: begin
        k_nxt = '0;
        if (in_acc) begin
          if (has_room) begin
            st_we     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_INIT: begin
        sp_nxt = '0;
        if (count_r >= CW'(2)) begin
          rs_we    = 1'b1;
          rs_waddr = '0;
          rs_wdata = {IW'(0), IW'(count_r - CW'(1))};
          sp_nxt   = CW'(1);
        end
      end
      ST_POP: begin
        if (sp_r != '0) sp_nxt = sp_dec;
      end
      ST_POP_W: begin
        lo_nxt   = rd_lo;
        hi_nxt   = rd_hi;
        st_raddr = rd_hi;
      end
      ST_PIV_W: begin
        pivot_nxt = st_rdata;
        bound_nxt = lo_r;
        j_nxt     = lo_r;
      end
      ST_SCAN_RD: begin
        st_raddr = scan_more ? j_r : bound_r;
      end
      ST_SCAN_CMP: begin
        vj_nxt   = st_rdata;
        st_raddr = bound_r;
        if (!is_less) j_nxt = j_r + IW'(1);
      end
      ST_SW_B: begin
        tmp_nxt  = st_rdata;
        st_we    = 1'b1;
        st_waddr = bound_r;
        st_wdata = vj_r;
      end
      ST_SW_J: begin
        st_we     = 1'b1;
        st_waddr  = j_r;
        st_wdata  = tmp_r;
        bound_nxt = bound_r + IW'(1);
        j_nxt     = j_r + IW'(1);
      end
      ST_FS_B: begin
        tmp_nxt  = st_rdata;
        st_we    = 1'b1;
        st_waddr = bound_r;
        st_wdata = pivot_r;
      end
      ST_FS_H: begin
        st_we    = 1'b1;
        st_waddr = hi_r;
        st_wdata = tmp_r;
      end
      ST_PUSH_L: begin
        // left part [lo, p-1], only if it holds two or more values
        if (bound_r > lo_r && lo_r < left_hi && sp_r < CW'(MAX_ITEMS)) begin
          rs_we  = 1'b1;
          sp_nxt = sp_r + CW'(1);
        end
      end
      ST_PUSH_R: begin
        rs_wdata = {right_lo[IW-1:0], hi_r};
        if (right_lo < {1'b0, hi_r} && sp_r < CW'(MAX_ITEMS)) begin
          rs_we  = 1'b1;
          sp_nxt = sp_r + CW'(1);
        end
      end
      ST_EMIT_RD: begin
        st_raddr = k_r[IW-1:0];
      end
      ST_EMIT_LD: begin
        out_nxt.sorted_value = st_rdata;
        out_nxt.run_end      = last_out;
        out_nxt.overflowed   = ovf_r;
        out_valid_nxt        = 1'b1;
      end
      ST_EMIT_HOLD: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (last_out) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            k_nxt     = '0;
            sp_nxt    = '0;
          end else begin
            k_nxt = k_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      sp_r        <= '0;
      k_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      k_r         <= k_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    bound_r <= bound_nxt;
    j_r     <= j_nxt;
    pivot_r <= pivot_nxt;
    vj_r    <= vj_nxt;
    tmp_r   <= tmp_nxt;
    out_r   <= out_nxt;
  end

  // no input is taken while a result is pending
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // closing a block stops the input side
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.block_end) |=> in_stall)
    else $error("input not stalled after block end");

  // single-element ranges are never pushed, so the stack is never more than half full
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(MAX_ITEMS / 2))
    else $error("range stack deeper than expected");

  // taking the final result empties the block
  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.run_end) |=> (count_r == '0 && !ovf_r))
    else $error("block not cleared after last result");

endmodule

`default_nettype wire
